// ===== sv/ack_driven_congestion_window_defines.svh =====
// ----------------------------------------------------------------------------
// ack_driven_congestion_window_defines.svh
// assertion macros shared by the congestion window rtl
// ----------------------------------------------------------------------------
`ifndef ACK_DRIVEN_CONGESTION_WINDOW_DEFINES_SVH
`define ACK_DRIVEN_CONGESTION_WINDOW_DEFINES_SVH
`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define ACW_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// consequent holds in the same cycle as the antecedent
`define ACW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent holds in the cycle after the antecedent
`define ACW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ACW_ASSERT(label, expr, msg)
`define ACW_ASSERT_IMPL(label, ante, cons, msg)
`define ACW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/acw_pkg.sv =====
// ----------------------------------------------------------------------------
// acw_pkg
// types and constants of the congestion window controller
// ----------------------------------------------------------------------------
package acw_pkg;

    localparam int START_W     = 12;
    localparam int SIZE_W      = 11;
    localparam int CNT_W       = 2;
    localparam int TICK_W      = 24;
    localparam int OP_W        = 2;
    localparam int ACKNUM_W    = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int EV_W        = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SIZE_W-1:0]  MAX_WINDOW_RST    = SIZE_W'(16);
    localparam logic [START_W-1:0] TOTAL_PACKETS_RST = START_W'(4095);
    localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RST = TICK_W'(5000000);

    typedef enum logic [OP_W-1:0] {
        OP_ACK  = 2'd0,
        OP_SENT = 2'd1,
        OP_TICK = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_WINDOW    = 2'd0,
        CFG_TOTAL_PACKETS = 2'd1,
        CFG_TIMEOUT_TICKS = 2'd2
    } cfg_index_t;

    typedef enum logic [EV_W-1:0] {
        EV_NONE     = 3'd0,
        EV_ADVANCED = 3'd1,
        EV_HALVED   = 3'd2,
        EV_TIMEOUT  = 3'd3,
        EV_INVALID  = 3'd4
    } event_t;

    // what the back end has to do with a beat
    typedef enum logic [2:0] {
        KIND_NOP     = 3'd0,
        KIND_ACK     = 3'd1,
        KIND_SENT    = 3'd2,
        KIND_TICK    = 3'd3,
        KIND_INVALID = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [START_W-1:0]  idx;
    } job_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   max_window;
        logic [START_W-1:0]  total_packets;
        logic [TICK_W-1:0]   timeout_ticks;
    } cfg_t;

endpackage

// ===== sv/acw_front.sv =====
// ----------------------------------------------------------------------------
// acw_front
// config registers, input beat acceptance and classification
// ----------------------------------------------------------------------------
module acw_front
    import acw_pkg::*;
#(
    parameter int unsigned PACKET_DEPTH = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       opcode,
    input  logic [ACKNUM_W-1:0]   ack_number,
    input  logic [START_W-1:0]    sent_index,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_full,
    input  logic                  clearing,
    output logic                  q_push,
    output job_t                  q_job,
    output cfg_t                  cfg
);

    cfg_t                cfg_reg;
    logic [ACKNUM_W-1:0] ack_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_window    <= MAX_WINDOW_RST;
            cfg_reg.total_packets <= TOTAL_PACKETS_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_WINDOW:    cfg_reg.max_window    <= cfg_data[SIZE_W-1:0];
                CFG_TOTAL_PACKETS: cfg_reg.total_packets <= cfg_data[START_W-1:0];
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg      = cfg_reg;
    assign in_ready = !clearing && !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        ack_idx    = ack_number - ACKNUM_W'(1);
        q_job.kind = KIND_NOP;
        q_job.idx  = sent_index;
        unique case (opcode)
            OP_ACK:
            begin
                q_job.idx = ack_idx[START_W-1:0];
                if (ack_number == '0 || ack_idx > {1'b0, cfg_reg.total_packets} ||
                    32'(ack_idx) >= 32'(PACKET_DEPTH))
                begin
                    q_job.kind = KIND_INVALID;
                end
                else
                begin
                    q_job.kind = KIND_ACK;
                end
            end
            OP_SENT:
            begin
                if (32'(sent_index) < 32'(PACKET_DEPTH))
                begin
                    q_job.kind = KIND_SENT;
                end
            end
            OP_TICK: q_job.kind = KIND_TICK;
            default: q_job.kind = KIND_NOP;
        endcase
    end

endmodule

// ===== sv/acw_queue.sv =====
// ----------------------------------------------------------------------------
// acw_queue
// short job queue between the front and back ends
// ----------------------------------------------------------------------------
`include "ack_driven_congestion_window_defines.svh"

module acw_queue
    import acw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t               slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full    = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

    `ACW_ASSERT(a_no_push_when_full, !(push && full), "queue push while full")
    `ACW_ASSERT(a_no_pop_when_empty, !(pop && empty), "queue pop while empty")

endmodule

// ===== sv/acw_back.sv =====
// ----------------------------------------------------------------------------
// acw_back
// per-packet stores, window state update and result register
// ----------------------------------------------------------------------------
`include "ack_driven_congestion_window_defines.svh"

module acw_back
    import acw_pkg::*;
#(
    parameter int unsigned PACKET_DEPTH = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_empty,
    input  job_t               q_job,
    output logic               q_pop,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [START_W-1:0] window_start,
    output logic [SIZE_W-1:0]  window_size,
    output logic [START_W-1:0] window_end,
    output logic [EV_W-1:0]    event_code
);

    localparam int ADDR_W = $clog2(PACKET_DEPTH);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    job_t                 job_reg;
    logic [START_W-1:0]   start_reg, start_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [START_W-1:0]   end_reg, end_next;
    logic [TICK_W-1:0]    tcnt_reg, tcnt_next;
    logic                 armed_reg, armed_next;
    logic                 out_valid_reg;
    logic [START_W-1:0]   out_start_reg;
    logic [SIZE_W-1:0]    out_size_reg;
    logic [START_W-1:0]   out_end_reg;
    event_t               out_ev_reg;

    logic [CNT_W-1:0]     ack_mem [PACKET_DEPTH];
    logic                 mark_mem [PACKET_DEPTH];
    logic [CNT_W-1:0]     ack_rd_reg;
    logic                 mark_rd_reg;

    logic                 out_free;
    logic                 exec_go;
    logic                 ack_we, mark_we;
    logic [ADDR_W-1:0]    ack_waddr, mark_waddr;
    logic [CNT_W-1:0]     ack_wdata;
    logic                 mark_wdata;
    logic                 ack_upd, mark_upd;
    logic [CNT_W-1:0]     ack_val;
    logic                 end_upd;
    event_t               ev;
    logic [SIZE_W:0]      dbl;
    logic [SIZE_W-1:0]    cap;
    logic [SIZE_W-1:0]    half;
    logic [TICK_W-1:0]    tcnt_dec;
    logic                 start_ok;
    logic [START_W:0]     end_sum;

    assign clearing = (state_reg == ST_CLEAR);
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || out_ready;
    assign exec_go  = (state_reg == ST_EXEC) && out_free;

    // one write port each, reads issued when a job leaves the queue
    assign ack_we     = clearing || (exec_go && ack_upd);
    assign ack_waddr  = clearing ? clr_cnt_reg : ADDR_W'(job_reg.idx);
    assign ack_wdata  = clearing ? '0 : ack_val;
    assign mark_we    = clearing || (exec_go && mark_upd);
    assign mark_waddr = clearing ? clr_cnt_reg : ADDR_W'(start_reg);
    assign mark_wdata = !clearing;

    always_ff @(posedge clk)
    begin
        if (ack_we)
        begin
            ack_mem[ack_waddr] <= ack_wdata;
        end
        if (q_pop)
        begin
            ack_rd_reg <= ack_mem[ADDR_W'(q_job.idx)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        if (q_pop)
        begin
            mark_rd_reg <= mark_mem[ADDR_W'(start_reg)];
        end
    end

    always_comb
    begin
        start_next = start_reg;
        size_next  = size_reg;
        tcnt_next  = tcnt_reg;
        armed_next = armed_reg;
        end_upd    = 1'b0;
        ev         = EV_NONE;
        ack_upd    = 1'b0;
        ack_val    = ack_rd_reg + CNT_W'(1);
        mark_upd   = 1'b0;
        dbl        = {size_reg, 1'b0};
        cap        = (cfg.max_window == '0) ? SIZE_W'(1) : cfg.max_window;
        half       = size_reg >> 1;
        tcnt_dec   = (tcnt_reg != '0) ? tcnt_reg - TICK_W'(1) : '0;
        start_ok   = 32'(start_reg) < 32'(PACKET_DEPTH);
        case (job_reg.kind)
            KIND_ACK:
            begin
                ack_upd = 1'b1;
                if (ack_rd_reg == '0)
                begin
                    // first ack of the window start moves the window
                    if (job_reg.idx == start_reg)
                    begin
                        start_next = (job_reg.idx == '1) ? job_reg.idx
                                                         : job_reg.idx + START_W'(1);
                        size_next  = (dbl <= {1'b0, cap}) ? dbl[SIZE_W-1:0] : cap;
                        end_upd    = 1'b1;
                        ev         = EV_ADVANCED;
                    end
                end
                else if (ack_rd_reg >= CNT_W'(2))
                begin
                    // third ack: back off
                    ack_val   = '0;
                    size_next = (half <= SIZE_W'(1)) ? SIZE_W'(1) : half;
                    end_upd   = 1'b1;
                    ev        = EV_HALVED;
                end
            end
            KIND_SENT:
            begin
                if (job_reg.idx == start_reg && !mark_rd_reg)
                begin
                    mark_upd   = 1'b1;
                    tcnt_next  = cfg.timeout_ticks;
                    armed_next = 1'b1;
                end
            end
            KIND_TICK:
            begin
                if (armed_reg)
                begin
                    tcnt_next = tcnt_dec;
                    if (tcnt_dec == '0 && start_ok && mark_rd_reg)
                    begin
                        size_next = SIZE_W'(1);
                        end_upd   = 1'b1;
                        ev        = EV_TIMEOUT;
                    end
                end
            end
            KIND_INVALID: ev = EV_INVALID;
            default: ;
        endcase
        end_sum  = {1'b0, start_next} + (START_W + 1)'(size_next) - (START_W + 1)'(1);
        end_next = end_reg;
        if (end_upd)
        begin
            end_next = (end_sum > {1'b0, cfg.total_packets}) ? cfg.total_packets
                                                              : end_sum[START_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(PACKET_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            start_reg     <= START_W'(1);
            size_reg      <= SIZE_W'(1);
            end_reg       <= START_W'(1);
            tcnt_reg      <= '0;
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (exec_go)
            begin
                start_reg <= start_next;
                size_reg  <= size_next;
                end_reg   <= end_next;
                tcnt_reg  <= tcnt_next;
                armed_reg <= armed_next;
            end
            if (exec_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (exec_go)
        begin
            out_start_reg <= start_next;
            out_size_reg  <= size_next;
            out_end_reg   <= end_next;
            out_ev_reg    <= ev;
        end
    end

    assign out_valid    = out_valid_reg;
    assign window_start = out_start_reg;
    assign window_size  = out_size_reg;
    assign window_end   = out_end_reg;
    assign event_code   = out_ev_reg;

    `ACW_ASSERT(a_size_nonzero, size_reg != '0, "window size reached zero")
    `ACW_ASSERT(a_end_in_window, 13'(end_reg) <= 13'(start_reg) + 13'(size_reg) - 13'd1, "window end past start plus size")
    `ACW_ASSERT_NEXT(a_exec_delivers, exec_go, out_valid_reg && state_reg == ST_IDLE, "executed job gave no result")
    `ACW_ASSERT_NEXT(a_timer_stays_armed, armed_reg, armed_reg, "timer disarmed")
    `ACW_ASSERT_IMPL(a_no_result_while_clearing, clearing, !out_valid_reg, "result during clearing pass")

endmodule

// ===== sv/ack_driven_congestion_window.sv =====
// ----------------------------------------------------------------------------
// ack_driven_congestion_window
// sender-side congestion window controller driven by ack, sent and tick beats
// ----------------------------------------------------------------------------
// after reset the block runs a clearing pass over the per-packet ack count and
// sent mark stores, one entry a cycle, and in_ready stays low until the pass
// ends (config writes are taken during that time); after that each input beat
// gives exactly one result beat; the back end reads both stores as a beat
// leaves the queue, then updates them and the window, and takes no new beat
// before it is done with the last one, which waits while out_ready is low; a two
// entry queue behind the input keeps accepting while a result waits, until full
module ack_driven_congestion_window
    import acw_pkg::*;
#(
    parameter int unsigned PACKET_DEPTH = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input beats
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       opcode,
    input  logic [ACKNUM_W-1:0]   ack_number,
    input  logic [START_W-1:0]    sent_index,
    // result beats
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [START_W-1:0]    window_start,
    output logic [SIZE_W-1:0]     window_size,
    output logic [START_W-1:0]    window_end,
    output logic [EV_W-1:0]       event_code,
    // config write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // front to queue
    logic q_push;
    job_t q_push_job;
    logic q_full;
    // queue to back
    logic q_pop;
    job_t q_pop_job;
    logic q_empty;
    // back status and config
    logic clearing;
    cfg_t cfg;

    // classify beats and hold the config registers
    acw_front #(
        .PACKET_DEPTH (PACKET_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .ack_number (ack_number),
        .sent_index (sent_index),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .clearing   (clearing),
        .q_push     (q_push),
        .q_job      (q_push_job),
        .cfg        (cfg)
    );

    // decouples acceptance from the store update
    acw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_pop_job),
        .empty    (q_empty)
    );

    // stores, window update and result register
    acw_back #(
        .PACKET_DEPTH (PACKET_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_job        (q_pop_job),
        .q_pop        (q_pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_start (window_start),
        .window_size  (window_size),
        .window_end   (window_end),
        .event_code   (event_code)
    );

endmodule
